// ===== rtl/dqp_pkg.sv =====
// shared types and constants for the dns query question parser
// no dependencies; imported by the parser, the result queue and the top level
package dqp_pkg;

	// header is 12 bytes, index of its last byte
	localparam logic [3:0] HDR_LAST = 4'd11;
	// type/class tail is 4 bytes, index of its last byte
	localparam logic [1:0] TAIL_LAST = 2'd3;
	// top two bits of a length byte: compression or reserved label type
	localparam logic [7:0] LABEL_TYPE_MASK = 8'hC0;
	localparam logic [7:0] DOT_CHAR = 8'h2E;
	// longest dotted name accepted
	localparam int unsigned MAX_NAME = 255;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_HDR_SHORT = 3'd1,
		ST_BAD_LABEL = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_TOO_LONG  = 3'd4,
		ST_NO_TAIL   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_LEN    = 3'd1,
		PH_DATA   = 3'd2,
		PH_SKIP   = 3'd3,
		PH_TAIL   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef struct packed {
		logic        is_report;
		logic [7:0]  name_char;
		status_t     status;
		logic [15:0] transaction_id;
		logic        recursion_desired;
		logic [15:0] question_count;
		logic [15:0] query_type;
		logic [15:0] query_class;
		logic [7:0]  name_length;
	} item_t;

	// up to two result items per input byte; push1 only with push0
	typedef struct packed {
		logic  push0;
		logic  push1;
		item_t item0;
		item_t item1;
	} push_t;

endpackage

// ===== rtl/dns_query_question_parser_core.sv =====
// top level of the dns query header and first-question parser
// depends on dqp_pkg, dqp_parser and dqp_result_queue
//
// Packet bytes come in one per transfer with an end-of-packet mark on the
// last one. The header gives the ID, RD flag and QDCOUNT; the first
// question's name then comes out as character items, a dot in place of each
// length byte after the first label, followed by QTYPE and QCLASS capture.
// Every packet ends with exactly one report item, sent at its final byte,
// that carries the status (ok, header short, bad label type, truncated
// label, name too long, missing type/class) and the captured fields; on an
// error the consumer drops the characters already sent. When a byte is
// taken, parser state updates in a single pass of logic and up to two
// result items (a character and the report) go into a four-entry result
// queue in the same cycle. The queue sends one item per cycle while
// result_ready is high, so bytes then stream at one per cycle; byte_ready
// drops only while the queue holds three or more items. Parser state
// clears itself after each report.
module dns_query_question_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic        is_report,
	output logic [7:0]  name_char,
	output logic [2:0]  status,
	output logic [15:0] transaction_id,
	output logic        recursion_desired,
	output logic [15:0] question_count,
	output logic [15:0] query_type,
	output logic [15:0] query_class,
	output logic [7:0]  name_length
);
	import dqp_pkg::*;

	logic  byte_xfer;
	push_t push;
	item_t head;

	// a byte transfers only when the queue can hold both of its results
	assign byte_xfer = byte_valid && byte_ready;

	dqp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (byte_xfer),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.push          (push)
	);

	dqp_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (result_ready),
		.room       (byte_ready),
		.head_valid (result_valid),
		.head       (head)
	);

	// result fields straight from the queue head
	assign is_report         = head.is_report;
	assign name_char         = head.name_char;
	assign status            = head.status;
	assign transaction_id    = head.transaction_id;
	assign recursion_desired = head.recursion_desired;
	assign question_count    = head.question_count;
	assign query_type        = head.query_type;
	assign query_class       = head.query_class;
	assign name_length       = head.name_length;

	// a stalled byte side means results are waiting
	a_stall_has_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> result_valid)
		else $error("byte side stalled with an empty result queue");

	// character items carry only the character
	a_char_item_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_report |-> status == ST_OK && transaction_id == 16'h0000
			&& question_count == 16'h0000 && query_type == 16'h0000)
		else $error("character item with report fields set");

	// type and class only reported on a clean finish
	a_error_no_type: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_report && status != ST_OK
			|-> query_type == 16'h0000 && query_class == 16'h0000)
		else $error("type/class reported with an error status");

	// a short header reports no header fields
	a_short_header: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_report && status == ST_HDR_SHORT
			|-> transaction_id == 16'h0000 && question_count == 16'h0000
				&& !recursion_desired && name_length == 8'h00)
		else $error("short header report with captured fields");

endmodule

// ===== rtl/dqp_parser.sv =====
// per-byte parser: state registers and the next-state / result logic
// depends on dqp_pkg
module dqp_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     data_byte,
	input  logic           end_of_packet,
	output dqp_pkg::push_t push
);
	import dqp_pkg::*;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  hdr_idx;
		logic [15:0] id;
		logic        rd;
		logic [15:0] qd;
		logic [5:0]  left;
		logic [7:0]  nlen;
		logic [1:0]  tail_idx;
		logic [31:0] tcw;
		status_t     held;
	} pstate_t;

	localparam pstate_t PSTATE_RESET = '{
		phase: PH_HEADER, hdr_idx: '0, id: '0, rd: 1'b0, qd: '0, left: '0,
		nlen: '0, tail_idx: '0, tcw: '0, held: ST_OK
	};
	localparam logic [9:0] MAX_NAME_W = 10'(MAX_NAME);

	pstate_t    state_q;
	pstate_t    state_n;
	pstate_t    step;
	status_t    end_status;
	logic       char_push;
	logic [7:0] char_val;
	logic [9:0] len_sum;
	logic [5:0] left_dec;
	logic       hdr_short;
	logic       full_ok;
	item_t      char_item;
	item_t      report_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PSTATE_RESET;
		end else if (accept) begin
			state_q <= state_n;
		end
	end

	assign len_sum  = 10'(state_q.nlen) + 10'(data_byte[5:0]) + 10'd1;
	assign left_dec = state_q.left - 6'd1;

	always_comb begin
		step       = state_q;
		end_status = ST_OK;
		char_push  = 1'b0;
		char_val   = '0;
		unique case (state_q.phase)
			PH_HEADER: begin
				case (state_q.hdr_idx)
					4'd0: step.id = {data_byte, 8'h00};
					4'd1: step.id[7:0] = data_byte;
					4'd2: step.rd = data_byte[0];
					4'd4: step.qd = {data_byte, 8'h00};
					4'd5: step.qd[7:0] = data_byte;
					default: ;
				endcase
				if (state_q.hdr_idx < HDR_LAST) begin
					step.hdr_idx = state_q.hdr_idx + 4'd1;
					end_status   = ST_HDR_SHORT;
				end else begin
					step.held = ST_OK;
					if (step.qd != '0) begin
						step.phase = PH_LEN;
						end_status = ST_NO_TAIL;
					end else begin
						step.phase = PH_DONE;
						end_status = ST_OK;
					end
				end
			end
			PH_LEN: begin
				if (data_byte == 8'h00) begin
					step.phase    = PH_TAIL;
					step.tail_idx = '0;
					end_status    = ST_NO_TAIL;
				end else if ((data_byte & LABEL_TYPE_MASK) != 8'h00) begin
					step.phase = PH_DONE;
					step.held  = ST_BAD_LABEL;
					end_status = ST_BAD_LABEL;
				end else begin
					step.left  = data_byte[5:0];
					end_status = ST_TRUNC;
					if (len_sum > MAX_NAME_W) begin
						step.phase = PH_SKIP;
					end else begin
						// dot stands in for every length byte after the first label
						if (state_q.nlen != '0) begin
							step.nlen = state_q.nlen + 8'd1;
							char_push = 1'b1;
							char_val  = DOT_CHAR;
						end
						step.phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				char_push = 1'b1;
				char_val  = data_byte;
				step.nlen = state_q.nlen + 8'd1;
				step.left = left_dec;
				if (left_dec == '0) begin
					step.phase = PH_LEN;
					end_status = ST_NO_TAIL;
				end else begin
					end_status = ST_TRUNC;
				end
			end
			PH_SKIP: begin
				step.left = left_dec;
				if (left_dec == '0) begin
					step.phase = PH_DONE;
					step.held  = ST_TOO_LONG;
					end_status = ST_TOO_LONG;
				end else begin
					end_status = ST_TRUNC;
				end
			end
			PH_TAIL: begin
				step.tcw = {state_q.tcw[23:0], data_byte};
				if (state_q.tail_idx == TAIL_LAST) begin
					step.phase = PH_DONE;
					step.held  = ST_OK;
					end_status = ST_OK;
				end else begin
					step.tail_idx = state_q.tail_idx + 2'd1;
					end_status    = ST_NO_TAIL;
				end
			end
			PH_DONE: end_status = state_q.held;
			default: end_status = state_q.held;
		endcase
	end

	// report fields come from the updated state, before the end-of-packet clear
	assign hdr_short = (end_status == ST_HDR_SHORT);
	assign full_ok   = (end_status == ST_OK) && (step.qd != '0);

	always_comb begin
		char_item           = '0;
		char_item.name_char = char_val;

		report_item                   = '0;
		report_item.is_report         = 1'b1;
		report_item.status            = end_status;
		report_item.transaction_id    = hdr_short ? 16'h0000 : step.id;
		report_item.recursion_desired = hdr_short ? 1'b0 : step.rd;
		report_item.question_count    = hdr_short ? 16'h0000 : step.qd;
		report_item.query_type        = full_ok ? step.tcw[31:16] : 16'h0000;
		report_item.query_class       = full_ok ? step.tcw[15:0] : 16'h0000;
		report_item.name_length       = step.nlen;

		state_n = end_of_packet ? PSTATE_RESET : step;
	end

	assign push.push0 = accept && (char_push || end_of_packet);
	assign push.push1 = accept && char_push && end_of_packet;
	assign push.item0 = char_push ? char_item : report_item;
	assign push.item1 = report_item;

endmodule

// ===== rtl/dqp_result_queue.sv =====
// four-entry result queue, takes up to two items per cycle, gives one per cycle while popped
// depends on dqp_pkg
module dqp_result_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  dqp_pkg::push_t push,
	input  logic           pop,
	output logic           room,
	output logic           head_valid,
	output dqp_pkg::item_t head
);
	import dqp_pkg::*;

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	item_t         slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic [PW-1:0] wr_ptr_p1;
	logic          do_pop;
	logic [PW:0]   push_n;

	assign wr_ptr_p1  = wr_ptr_q + PW'(1);
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign push_n     = (PW+1)'(push.push0) + (PW+1)'(push.push1);
	// space for a two-item byte
	assign room       = (count_q <= (PW+1)'(DEPTH - 2));
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + push_n - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.push0) begin
			slots_q[wr_ptr_q] <= push.item0;
		end
		if (push.push1) begin
			slots_q[wr_ptr_p1] <= push.item1;
		end
	end

endmodule
